// File: sv/acs_pkg.sv
package acs_pkg;

  // parameter defaults
  localparam int DEF_MAX_OVERSAMPLE = 8;
  localparam int DEF_WORD_BITS      = 16;

  // register file
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FACTOR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_STEREO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_STEREO      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_16BIT       = 3'd5;

  localparam logic [3:0]  RST_OVERSAMPLE_COUNT = 4'd2;
  localparam logic [7:0]  RST_NOISE_LEVEL      = 8'd0;
  localparam logic [15:0] RST_GAIN_FACTOR      = 16'd1024;

  // datapath widths
  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = 32;  // dc tracker, filter state, work values
  localparam int DCX_W    = 36;  // dc update headroom
  localparam int MULB_W   = 17;  // unsigned multiplier operand
  localparam int MUL_W    = DATA_W + MULB_W + 1;
  localparam int RES_W    = 41;  // value after gain

  // output clamps
  localparam int CLAMP_LO = -32768 + 16;
  localparam int CLAMP_HI = 32767 - 16;
  localparam int BYTE_MAX = 255;
  localparam int HALF_LSB = 128;
  localparam int UNITY_WEIGHT = 256;

endpackage

// File: sv/acs_if.sv
interface acs_in_if #(
  parameter int WORD_BITS = acs_pkg::DEF_WORD_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] first_word;
  logic signed [WORD_BITS-1:0] second_word;

  modport source (output valid, first_word, second_word, input ready);
  modport sink   (input valid, first_word, second_word, output ready);
endinterface

interface acs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  logic               group_last;

  modport source (output valid, sample_out, group_last, input ready);
  modport sink   (input valid, sample_out, group_last, output ready);
endinterface

interface acs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/audio_sample_conditioner_core.sv
// Audio sample conditioner.
// in_frame : one item per frame of two microphone words. Frames are summed
//            per slot; every oversample_count-th frame closes a group.
// out_sample: one to four items per closed group; group_last marks the last.
// cfg      : register writes, always ready; write only while the block idles.
// Timing: a frame that does not close a group is only summed, and ready
//   stays high. A closing frame starts the sequencer, which drives one
//   shared multiplier: dc update, correction, then per slot either five
//   steps (filter on: two filter products, sum, gain product, truncate)
//   or two (gain only), then an output load. After the first result,
//   the following ones come one per cycle while the receiver takes them.
//   in_frame.ready is low from the closing frame until the last result of
//   the group is taken.
// Receiver stall: the result register holds its item; nothing is lost.
// Reset: registers return to their defaults, sums, dc tracker and filter
//   state clear, the group counter reloads to 2, no result is pending.
module audio_sample_conditioner_core #(
  parameter int MAX_OVERSAMPLE = acs_pkg::DEF_MAX_OVERSAMPLE,
  parameter int WORD_BITS      = acs_pkg::DEF_WORD_BITS
) (
  input  logic       clk,
  input  logic       rst,
  acs_in_if.sink     in_frame,
  acs_out_if.source  out_sample,
  acs_cfg_if.sink    cfg
);
  import acs_pkg::*;

  localparam int FL_W  = $clog2(MAX_OVERSAMPLE + 2);
  localparam int SUM_W = WORD_BITS + FL_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DC   = 4'd1;  // dc tracker update
  localparam logic [3:0] ST_CORR = 4'd2;  // add correction to both slots
  localparam logic [3:0] ST_MA   = 4'd3;  // value * (256 - level)
  localparam logic [3:0] ST_MB   = 4'd4;  // previous * level
  localparam logic [3:0] ST_FSUM = 4'd5;  // filter sum and round
  localparam logic [3:0] ST_MG   = 4'd6;  // value * gain
  localparam logic [3:0] ST_GST  = 4'd7;  // truncate toward zero
  localparam logic [3:0] ST_LOAD = 4'd8;  // first result into out register
  localparam logic [3:0] ST_EMIT = 4'd9;

  // configuration registers
  logic [3:0]  oversample_count;
  logic [7:0]  noise_level;
  logic [15:0] gain_factor;
  logic        source_stereo;
  logic        dest_stereo;
  logic        dest_16bit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      oversample_count <= RST_OVERSAMPLE_COUNT;
      noise_level      <= RST_NOISE_LEVEL;
      gain_factor      <= RST_GAIN_FACTOR;
      source_stereo    <= 1'b0;
      dest_stereo      <= 1'b0;
      dest_16bit       <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OVERSAMPLE_COUNT: oversample_count <= cfg.data[3:0];
        REG_NOISE_LEVEL:      noise_level      <= cfg.data[7:0];
        REG_GAIN_FACTOR:      gain_factor      <= cfg.data;
        REG_SOURCE_STEREO:    source_stereo    <= cfg.data[0];
        REG_DEST_STEREO:      dest_stereo      <= cfg.data[0];
        REG_DEST_16BIT:       dest_16bit       <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // state
  logic [3:0]                state;
  logic                      slot;
  logic [1:0]                k;
  logic [FL_W-1:0]           frames_left;
  logic signed [SUM_W-1:0]   slot_sum0, slot_sum1;
  logic signed [DATA_W-1:0]  dc_offset;
  logic signed [DATA_W-1:0]  prev0, prev1;
  logic signed [DATA_W-1:0]  w0, w1;
  logic signed [MUL_W-1:0]   acc;
  logic signed [RES_W-1:0]   r0, r1;
  logic                      out_valid;
  logic signed [SAMPLE_W-1:0] out_data;
  logic                      out_last;

  // frame intake
  logic                      in_acc;
  logic signed [WORD_BITS-1:0] word_a, word_b;
  logic signed [SUM_W-1:0]   sum_a, sum_b;
  logic [FL_W-1:0]           group_size;
  logic [4:0]                oc_ext;

  assign in_frame.ready = (state == ST_IDLE);
  assign in_acc = in_frame.valid && in_frame.ready;
  assign word_a = $signed(in_frame.first_word[WORD_BITS-1:0]);
  assign word_b = $signed(in_frame.second_word[WORD_BITS-1:0]);
  assign sum_a  = slot_sum0 + SUM_W'(word_a);
  assign sum_b  = slot_sum1 + SUM_W'(word_b);
  assign oc_ext = {1'b0, oversample_count};

  always_comb begin
    if (oc_ext == 5'd0) begin
      group_size = FL_W'(1);
    end else if (oc_ext > 5'(MAX_OVERSAMPLE)) begin
      group_size = FL_W'(MAX_OVERSAMPLE);
    end else begin
      group_size = FL_W'(oc_ext);
    end
  end

  // dc tracker and correction
  logic signed [DCX_W-1:0]  t_x, dc_x, dc_shift;
  logic signed [DATA_W-1:0] dc_new;
  logic signed [DATA_W:0]   c_x, c_shift;

  always_comb begin
    t_x      = (DCX_W'(w0) + DCX_W'(w1)) <<< 3;
    dc_x     = t_x + DCX_W'(dc_offset) + DCX_W'(16);
    dc_shift = dc_x >>> 5;
    dc_new   = dc_offset - dc_shift[DATA_W-1:0];
    c_x      = (DATA_W+1)'(dc_offset) + (DATA_W+1)'(8);
    c_shift  = c_x >>> 4;
  end

  // shared multiplier
  logic signed [DATA_W-1:0] mul_a;
  logic        [MULB_W-1:0] mul_b;
  logic signed [MUL_W-1:0]  prod;
  logic signed [DATA_W-1:0] w_cur, prev_cur;

  assign w_cur    = slot ? w1 : w0;
  assign prev_cur = slot ? prev1 : prev0;

  always_comb begin
    case (state)
      ST_MA: begin
        mul_a = w_cur;
        mul_b = MULB_W'(UNITY_WEIGHT) - MULB_W'(noise_level);
      end
      ST_MB: begin
        mul_a = prev_cur;
        mul_b = MULB_W'(noise_level);
      end
      default: begin
        mul_a = w_cur;
        mul_b = MULB_W'(gain_factor);
      end
    endcase
  end

  acs_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // filter rounding and gain truncation
  logic signed [MUL_W:0]    f_x;
  logic signed [DATA_W-1:0] f_val;
  logic signed [MUL_W-1:0]  g_x;
  logic signed [RES_W-1:0]  g_val;

  always_comb begin
    f_x   = (MUL_W+1)'(acc) + (MUL_W+1)'(prod) + (MUL_W+1)'(HALF_LSB);
    f_val = f_x[DATA_W+7:8];
    g_x   = prod + (prod[MUL_W-1] ? MUL_W'(255) : MUL_W'(0));
    g_val = g_x[RES_W+7:8];
  end

  // layout: pick the value for result index emit_idx
  logic signed [RES_W:0]    avg_x;
  logic [1:0]               last_idx;
  logic [1:0]               emit_idx;
  logic signed [RES_W-1:0]  pick;
  logic signed [SAMPLE_W-1:0] fmt_sample;

  assign avg_x    = (RES_W+1)'(r0) + (RES_W+1)'(r1) + (RES_W+1)'(1);
  assign emit_idx = (state == ST_EMIT) ? k + 2'd1 : 2'd0;

  always_comb begin
    if (source_stereo == dest_stereo) begin
      last_idx = dest_stereo ? 2'd1 : 2'd0;
      pick     = (dest_stereo && emit_idx[0]) ? r1 : r0;
    end else if (source_stereo) begin
      // stereo to mono: rounded average
      last_idx = 2'd0;
      pick     = avg_x[RES_W:1];
    end else begin
      // mono to stereo: each slot twice
      last_idx = 2'd3;
      pick     = emit_idx[1] ? r1 : r0;
    end
  end

  acs_fmt u_fmt (
    .value      (pick),
    .dest_16bit (dest_16bit),
    .sample     (fmt_sample)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      slot        <= 1'b0;
      k           <= 2'd0;
      frames_left <= FL_W'(RST_OVERSAMPLE_COUNT);
      slot_sum0   <= '0;
      slot_sum1   <= '0;
      dc_offset   <= '0;
      prev0       <= '0;
      prev1       <= '0;
      out_valid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (frames_left > FL_W'(1)) begin
              frames_left <= frames_left - FL_W'(1);
              slot_sum0   <= sum_a;
              slot_sum1   <= sum_b;
            end else begin
              frames_left <= group_size;
              slot_sum0   <= '0;
              slot_sum1   <= '0;
              w0          <= DATA_W'(sum_a);
              w1          <= DATA_W'(sum_b);
              state       <= ST_DC;
            end
          end
        end
        ST_DC: begin
          dc_offset <= dc_new;
          state     <= ST_CORR;
        end
        ST_CORR: begin
          w0    <= w0 + DATA_W'(c_shift);
          w1    <= w1 + DATA_W'(c_shift);
          slot  <= 1'b0;
          state <= (noise_level != 8'd0) ? ST_MA : ST_MG;
        end
        ST_MA: begin
          state <= ST_MB;
        end
        ST_MB: begin
          acc   <= prod;
          state <= ST_FSUM;
        end
        ST_FSUM: begin
          if (slot) begin
            w1    <= f_val;
            prev1 <= f_val;
          end else begin
            w0    <= f_val;
            prev0 <= f_val;
          end
          state <= ST_MG;
        end
        ST_MG: begin
          state <= ST_GST;
        end
        ST_GST: begin
          if (slot) begin
            r1    <= g_val;
            state <= ST_LOAD;
          end else begin
            r0    <= g_val;
            slot  <= 1'b1;
            state <= (noise_level != 8'd0) ? ST_MA : ST_MG;
          end
        end
        ST_LOAD: begin
          k         <= 2'd0;
          out_data  <= fmt_sample;
          out_last  <= (last_idx == 2'd0);
          out_valid <= 1'b1;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_sample.ready) begin
            if (out_last) begin
              out_valid <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              k        <= emit_idx;
              out_data <= fmt_sample;
              out_last <= (emit_idx == last_idx);
            end
          end
        end
        default: begin
          state     <= ST_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  assign out_sample.valid      = out_valid;
  assign out_sample.sample_out = out_data;
  assign out_sample.group_last = out_last;

endmodule

// File: sv/acs_mul.sv
module acs_mul (
  input  logic                                clk,
  input  logic signed [acs_pkg::DATA_W-1:0]   a,
  input  logic        [acs_pkg::MULB_W-1:0]   b,
  output logic signed [acs_pkg::MUL_W-1:0]    prod
);
  import acs_pkg::*;

  // signed x unsigned, registered
  always_ff @(posedge clk) begin
    prod <= a * $signed({1'b0, b});
  end

endmodule

// File: sv/acs_fmt.sv
module acs_fmt (
  input  logic signed [acs_pkg::RES_W-1:0]    value,
  input  logic                                dest_16bit,
  output logic signed [acs_pkg::SAMPLE_W-1:0] sample
);
  import acs_pkg::*;

  logic signed [RES_W:0] biased;
  logic signed [RES_W:0] shifted;
  logic signed [RES_W:0] byte_val;

  always_comb begin
    biased   = (RES_W+1)'(value) + (RES_W+1)'(HALF_LSB);
    shifted  = biased >>> 8;
    byte_val = shifted + (RES_W+1)'(HALF_LSB);
    if (dest_16bit) begin
      if (value < CLAMP_LO) begin
        sample = SAMPLE_W'(CLAMP_LO);
      end else if (value > CLAMP_HI) begin
        sample = SAMPLE_W'(CLAMP_HI);
      end else begin
        sample = value[SAMPLE_W-1:0];
      end
    end else begin
      if (byte_val < 0) begin
        sample = '0;
      end else if (byte_val > BYTE_MAX) begin
        sample = SAMPLE_W'(BYTE_MAX);
      end else begin
        sample = byte_val[SAMPLE_W-1:0];
      end
    end
  end

endmodule

// File: sv/acs_checker.sv
module acs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample,
  input logic        out_last
);

  // frames are refused while a group is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // reset leaves nothing pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // the last item of a group ends delivery
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result follows the last item of a group");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_sample) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind audio_sample_conditioner_core acs_checker u_acs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_frame.ready),
  .out_valid  (out_sample.valid),
  .out_ready  (out_sample.ready),
  .out_sample (out_sample.sample_out),
  .out_last   (out_sample.group_last)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import acs_pkg::*;

  // Timing
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off, fills the block up
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 26;

  // Spare register indexes; writes to these must change nothing
  localparam logic [2:0] REG_UNUSED_A = 3'd6;
  localparam logic [2:0] REG_UNUSED_B = 3'd7;
  localparam logic [2:0] IDX_NONE     = '0;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } pcm_result_t;

  // One row of the directed plan: a frame item or a register write
  typedef enum logic {ROW_FRAME, ROW_WRITE} plan_kind_t;

  typedef struct packed {
    plan_kind_t         kind;
    logic [2:0]         idx;   // register index on a write
    logic [15:0]        a;     // first word, or write data
    logic [15:0]        b;     // second word
    logic               typed; // expectation typed into the row
    logic signed [15:0] want;
  } plan_row_t;

  localparam int PLAN_LEN = 41;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset defaults: two frames per group, gain x4, mono to mono, 16-bit
    '{ROW_FRAME, IDX_NONE, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h0000, 16'h0000, 1'b1, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h7FFF, 16'h7FFF, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h7FFF, 16'h7FFF, 1'b1, 16'(CLAMP_HI)},
    '{ROW_FRAME, IDX_NONE, 16'h8000, 16'h8000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h8000, 16'h8000, 1'b1, 16'(CLAMP_LO)},
    // count masked to its four bits; spare indexes ignored
    '{ROW_WRITE, REG_OVERSAMPLE_COUNT, 16'hFFF1, 16'h0000, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_UNUSED_A, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_UNUSED_B, 16'h5A5A, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h5555, 16'hAAAA, 1'b0, 16'sd0},
    // count of zero acts as one
    '{ROW_WRITE, REG_OVERSAMPLE_COUNT, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'hAAAA, 16'h5555, 1'b0, 16'sd0},
    // count above the maximum acts as the maximum
    '{ROW_WRITE, REG_OVERSAMPLE_COUNT, 16'h000F, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h1234, 16'hEDCC, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h0001, 16'hFFFF, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'hFFFF, 16'h0001, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h4000, 16'hC000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h0100, 16'h0100, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h7FFF, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h0000, 16'h8000, 1'b0, 16'sd0},
    // count changed with six frames of the group in: group still takes eight
    '{ROW_WRITE, REG_OVERSAMPLE_COUNT, 16'h0001, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h2222, 16'hDDDE, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h0F0F, 16'hF0F0, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h00FF, 16'hFF00, 1'b0, 16'sd0},
    // stereo to stereo
    '{ROW_WRITE, REG_SOURCE_STEREO, 16'h0001, 16'h0000, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_DEST_STEREO, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h3000, 16'hD000, 1'b0, 16'sd0},
    // stereo averaged to mono
    '{ROW_WRITE, REG_DEST_STEREO, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h7FFF, 16'h7FFF, 1'b0, 16'sd0},
    // mono duplicated to four items
    '{ROW_WRITE, REG_SOURCE_STEREO, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_DEST_STEREO, 16'h0001, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h1000, 16'hF000, 1'b0, 16'sd0},
    // heaviest filter, largest gain
    '{ROW_WRITE, REG_NOISE_LEVEL, 16'h00FF, 16'h0000, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_GAIN_FACTOR, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h7FFF, 16'h8000, 1'b0, 16'sd0},
    // biased 8-bit output at both ends
    '{ROW_WRITE, REG_DEST_16BIT, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h7FFF, 16'h7FFF, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h8000, 16'h8000, 1'b0, 16'sd0},
    // zero gain
    '{ROW_WRITE, REG_NOISE_LEVEL, 16'h0080, 16'h0000, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_GAIN_FACTOR, 16'h0000, 16'h0000, 1'b0, 16'sd0},
    '{ROW_FRAME, IDX_NONE, 16'h1000, 16'hF000, 1'b0, 16'sd0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  acs_in_if  in_frame();
  acs_out_if out_sample();
  acs_cfg_if cfg();

  audio_sample_conditioner_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_frame   (in_frame),
    .out_sample (out_sample),
    .cfg        (cfg)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Shadow copy of the register file
  logic [3:0]  os_count_r   = RST_OVERSAMPLE_COUNT;
  logic [7:0]  noise_r      = RST_NOISE_LEVEL;
  logic [15:0] gain_r       = RST_GAIN_FACTOR;
  logic        src_stereo_r = 1'b0;
  logic        dst_stereo_r = 1'b0;
  logic        dst_16bit_r  = 1'b1;

  // Conditioner state as the predictor sees it
  longint      grp_sum [2]     = '{0, 0};
  int unsigned frames_to_go    = RST_OVERSAMPLE_COUNT;
  int          dc_est          = 0;   // wraps at 32 bits
  longint      smooth_prev [2] = '{0, 0};

  pcm_result_t pending_pcm [$];       // samples owed by the block, oldest first
  int          mismatches     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  logic        recv_hold      = 1'b0;
  event        hold_kick;

  // Predicts the samples one frame item causes; returns how many (0..4).
  function automatic int condition_frame(input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         output pcm_result_t res [4]);
    longint s [4];
    longint t, c, v, p;
    int     n, i;
    grp_sum[0] += a;
    grp_sum[1] += b;
    if (frames_to_go > 1) begin
      frames_to_go--;
      return 0;
    end
    // group closed: reload from the count as it stands now
    if (os_count_r == 0) frames_to_go = 1;
    else if (os_count_r > DEF_MAX_OVERSAMPLE) frames_to_go = DEF_MAX_OVERSAMPLE;
    else frames_to_go = os_count_r;
    s[0] = grp_sum[0];
    s[1] = grp_sum[1];
    grp_sum[0] = 0;
    grp_sum[1] = 0;

    // leaky dc tracker shared by both slots
    t = (s[0] + s[1]) * 8;
    dc_est = int'(longint'(dc_est) - ((t + dc_est + 16) >>> 5));
    c = (longint'(dc_est) + 8) >>> 4;

    for (i = 0; i < 2; i++) begin
      v = s[i] + c;
      if (noise_r != 0) begin
        v = (v * (UNITY_WEIGHT - longint'(noise_r))
             + smooth_prev[i] * longint'(noise_r) + HALF_LSB) >>> 8;
        smooth_prev[i] = v;
      end
      p = v * longint'(gain_r);
      s[i] = p / 256;   // signed divide truncates toward zero
    end

    n = dst_stereo_r ? 2 : 1;
    if (src_stereo_r && !dst_stereo_r) begin
      s[0] = (s[0] + s[1] + 1) >>> 1;
      n = 1;
    end else if (!src_stereo_r && dst_stereo_r) begin
      s[3] = s[1];
      s[2] = s[1];
      s[1] = s[0];
      n = 4;
    end

    for (i = 0; i < n; i++) begin
      if (dst_16bit_r) begin
        v = s[i];
        if (v < CLAMP_LO) v = CLAMP_LO;
        else if (v > CLAMP_HI) v = CLAMP_HI;
      end else begin
        v = ((s[i] + HALF_LSB) >>> 8) + HALF_LSB;
        if (v < 0) v = 0;
        else if (v > BYTE_MAX) v = BYTE_MAX;
      end
      res[i].sample = 16'(v);
      res[i].last   = (i == n - 1);
    end
    return n;
  endfunction

  // Half full-range words, with extremes and small values mixed in
  function automatic logic [15:0] draw_word();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return 16'($urandom_range(0, 2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one frame item; valid is left high so a following item can go
  // straight out on the next cycle.
  task automatic offer_frame(input logic [15:0] a, input logic [15:0] b,
                             input logic typed, input logic signed [15:0] want);
    pcm_result_t res [4];
    int          n, i, gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_frame.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_frame.valid       <= 1'b1;
    in_frame.first_word  <= a;
    in_frame.second_word <= b;
    @(posedge clk);
    while (!in_frame.ready) @(posedge clk);
    n = condition_frame(a, b, res);
    if (typed) begin
      pending_pcm.push_back('{sample: want, last: 1'b1});
    end else begin
      for (i = 0; i < n; i++) pending_pcm.push_back(res[i]);
    end
  endtask

  // Stops sending and waits until the block has handed over everything
  task automatic drain_block();
    in_frame.valid <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_OVERSAMPLE_COUNT: os_count_r   = val[3:0];
      REG_NOISE_LEVEL:      noise_r      = val[7:0];
      REG_GAIN_FACTOR:      gain_r       = val;
      REG_SOURCE_STEREO:    src_stereo_r = val[0];
      REG_DEST_STEREO:      dst_stereo_r = val[0];
      REG_DEST_16BIT:       dst_16bit_r  = val[0];
      default: ;
    endcase
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Long receiver hold-off, counted here so the sender keeps going meanwhile
  initial begin : long_hold
    forever begin
      @(hold_kick);
      recv_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      recv_hold <= 1'b0;
    end
  end

  // Receiver: takes result items, checks each against the oldest owed one
  initial begin : result_sink
    pcm_result_t want;
    out_sample.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_sample.valid && out_sample.ready) begin
        if (pending_pcm.size() == 0) begin
          $display("%0t: unexpected item: expected none, got sample %0d last %0b",
                   $time, out_sample.sample_out, out_sample.group_last);
          mismatches++;
        end else begin
          want = pending_pcm.pop_front();
          if (out_sample.sample_out !== want.sample) begin
            $display("%0t: sample_out: expected %0d, got %0d",
                     $time, want.sample, out_sample.sample_out);
            mismatches++;
          end
          if (out_sample.group_last !== want.last) begin
            $display("%0t: group_last: expected %0b, got %0b",
                     $time, want.last, out_sample.group_last);
            mismatches++;
          end
        end
      end
      out_sample.ready <= !rst && !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    int          i, p, k, mode;
    logic [3:0]  cnt;
    logic [7:0]  lvl;
    logic [15:0] gn;

    in_frame.valid       <= 1'b0;
    in_frame.first_word  <= '0;
    in_frame.second_word <= '0;
    cfg.valid            <= 1'b0;
    cfg.index            <= '0;
    cfg.data             <= '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan: writes wait for the block to go quiet first
    for (i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        drain_block();
        write_reg(PLAN[i].idx, PLAN[i].a);
      end else begin
        offer_frame(PLAN[i].a, PLAN[i].b, PLAN[i].typed, PLAN[i].want);
      end
    end

    // Random phases, each with a fresh register setting and idling pattern
    for (p = 0; p < PHASES; p++) begin
      drain_block();
      case (p)
        0: begin cnt = 4'd1; lvl = 8'd0;   gn = 16'hFFFF; end
        1: begin cnt = 4'd8; lvl = 8'd255; gn = 16'd256;  end
        default: begin
          // short groups mostly, so results stay frequent
          cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 3));
          lvl = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
          gn  = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(128, 2048));
        end
      endcase
      // upper bits random: the block must mask them off
      write_reg(REG_OVERSAMPLE_COUNT, {12'($urandom), cnt});
      write_reg(REG_NOISE_LEVEL, {8'($urandom), lvl});
      write_reg(REG_GAIN_FACTOR, gn);
      write_reg(REG_SOURCE_STEREO, {15'($urandom), 1'($urandom)});
      write_reg(REG_DEST_STEREO, {15'($urandom), 1'($urandom)});
      write_reg(REG_DEST_16BIT, {15'($urandom), 1'($urandom)});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED_A, 16'($urandom));

      // none, sender idle, receiver stall, both
      mode = p % 4;
      send_idle_pct = (mode == 1) ? 57 : (mode == 3) ? 21 : 0;
      recv_stall_pct <= (mode == 2) ? 57 : (mode == 3) ? 21 : 0;

      // receiver holds off while frames keep coming, so input backs up
      if (p == 4) -> hold_kick;

      for (k = 0; k < PHASE_ITEMS; k++) begin
        // sender pauses mid-phase until everything owed has arrived
        if (p == 6 && k == PHASE_ITEMS / 2) drain_block();
        offer_frame(draw_word(), draw_word(), 1'b0, 16'sd0);
      end
    end

    drain_block();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
